// ===== rtl/vector_clock_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Vector clock tracker assertion macros
// Concurrent assertion helpers shared by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef VECTOR_CLOCK_TRACKER_DEFINES_SVH
`define VECTOR_CLOCK_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define VCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector clock tracker assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define VCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector clock tracker assertion failed");
`else
`define VCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/vct_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker package
// Sizes, command codes, types and helpers shared by the tracker RTL.
// ----------------------------------------------------------------------------
package vct_pkg;

    localparam int NUM_THREADS = 8;
    localparam int NUM_LOCKS   = 16;
    localparam int CLOCK_BITS  = 32;

    // Fixed field widths of the event and result items.
    localparam int CMD_W   = 2;
    localparam int TID_W   = 3;
    localparam int LID_W   = 4;
    localparam int EIDX_W  = 3;
    localparam int VALUE_W = 32;

    localparam int ELEM_W     = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int CNT_W      = $clog2(NUM_THREADS + 1);
    localparam int LROW_W     = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int THR_DEPTH  = NUM_THREADS * NUM_THREADS;
    localparam int LOCK_DEPTH = NUM_LOCKS * NUM_THREADS;
    localparam int THR_AW     = (THR_DEPTH > 1) ? $clog2(THR_DEPTH) : 1;
    localparam int LOCK_AW    = (LOCK_DEPTH > 1) ? $clog2(LOCK_DEPTH) : 1;

    localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    typedef logic [CLOCK_BITS-1:0] clock_t;

    localparam clock_t CLOCK_MAX = '1;
    localparam clock_t CLOCK_ONE = clock_t'(1);

    // Control from the sequencer to the datapath and memories.
    typedef struct packed {
        logic              issue;
        logic [ELEM_W-1:0] issue_elem;
        logic              adv;
        logic [ELEM_W-1:0] rd_elem;
        logic              is_last;
        logic              err_load;
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] tid_row;
        logic [LROW_W-1:0] lid_row;
        logic              tval;
        logic              lval;
    } vct_ctl_t;

    // Low bits of a component as carried on the result channel.
    function automatic logic [VALUE_W-1:0] to_out(clock_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[VALUE_W-1:0];
    endfunction

    function automatic clock_t clock_max(clock_t a, clock_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/vct_evt_if.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker event channel
// Valid/ready channel carrying one event item.
// ----------------------------------------------------------------------------
interface vct_evt_if import vct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] thread_id;
    logic [LID_W-1:0] lock_id;

    modport source (output valid, output cmd, output thread_id, output lock_id,
                    input ready);
    modport sink   (input valid, input cmd, input thread_id, input lock_id,
                    output ready);
endinterface

// ===== rtl/vct_res_if.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker result channel
// Valid/ready channel carrying one snapshot element item.
// ----------------------------------------------------------------------------
interface vct_res_if import vct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EIDX_W-1:0]  element_index;
    logic [VALUE_W-1:0] clock_value;
    logic               last;
    logic               error;

    modport source (output valid, output element_index, output clock_value,
                    output last, output error, input ready);
    modport sink   (input valid, input element_index, input clock_value,
                    input last, input error, output ready);
endinterface

// ===== rtl/vector_clock_tracker.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker
// Happens-before vector clock engine for threads and locks.
// ----------------------------------------------------------------------------
// Each event item (access, acquire or release) produces a snapshot of the
// issuing thread's vector, one result item per thread component in index
// order, with last set on the final one; an out-of-range thread or lock gives
// a single error item and changes nothing. Thread and lock vectors live in two
// synchronous RAMs and are updated one component per cycle by a read, a join
// and a write-back while the result side takes each result; a stall on the
// result side holds the update. The next item is accepted only once the last
// component is written back, while the final result still waits in the output
// register. Reset values come from per-row written flags, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module vector_clock_tracker import vct_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    vct_evt_if.sink   evt,
    vct_res_if.source res
);

    vct_ctl_t ctl;
    logic     out_free;

    logic [THR_AW-1:0]  thr_raddr, thr_waddr;
    logic [LOCK_AW-1:0] lock_raddr, lock_waddr;
    clock_t             thr_rdata, lock_rdata;
    clock_t             thr_new, lock_new;
    logic               lock_we;
    logic               own;

    logic               out_valid_reg, out_valid_next;
    logic [EIDX_W-1:0]  out_elem_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_error_reg;

    assign out_free = !out_valid_reg || res.ready;

    vct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .out_free (out_free),
        .ctl      (ctl)
    );

    always_comb
    begin
        thr_raddr  = THR_AW'(ctl.tid_row) * THR_AW'(NUM_THREADS) + THR_AW'(ctl.issue_elem);
        thr_waddr  = THR_AW'(ctl.tid_row) * THR_AW'(NUM_THREADS) + THR_AW'(ctl.rd_elem);
        lock_raddr = LOCK_AW'(ctl.lid_row) * LOCK_AW'(NUM_THREADS) +
                     LOCK_AW'(ctl.issue_elem);
        lock_waddr = LOCK_AW'(ctl.lid_row) * LOCK_AW'(NUM_THREADS) + LOCK_AW'(ctl.rd_elem);
        lock_we    = ctl.adv && (ctl.cmd == CMD_RELEASE);
        own        = (ctl.rd_elem == ctl.tid_row);
    end

    vct_ram #(
        .DEPTH (THR_DEPTH),
        .WIDTH (CLOCK_BITS),
        .AW    (THR_AW)
    ) u_thr_ram (
        .clk   (clk),
        .we    (ctl.adv),
        .waddr (thr_waddr),
        .wdata (thr_new),
        .re    (ctl.issue),
        .raddr (thr_raddr),
        .rdata (thr_rdata)
    );

    vct_ram #(
        .DEPTH (LOCK_DEPTH),
        .WIDTH (CLOCK_BITS),
        .AW    (LOCK_AW)
    ) u_lock_ram (
        .clk   (clk),
        .we    (lock_we),
        .waddr (lock_waddr),
        .wdata (lock_new),
        .re    (ctl.issue),
        .raddr (lock_raddr),
        .rdata (lock_rdata)
    );

    vct_join u_join (
        .cmd        (ctl.cmd),
        .own        (own),
        .tval       (ctl.tval),
        .lval       (ctl.lval),
        .thr_rdata  (thr_rdata),
        .lock_rdata (lock_rdata),
        .thr_new    (thr_new),
        .lock_new   (lock_new)
    );

    always_comb
    begin
        if (ctl.adv || ctl.err_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            out_elem_reg  <= EIDX_W'(ctl.rd_elem);
            out_value_reg <= to_out(thr_new);
            out_last_reg  <= ctl.is_last;
            out_error_reg <= 1'b0;
        end
        else if (ctl.err_load)
        begin
            out_elem_reg  <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
            out_error_reg <= 1'b1;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.element_index = out_elem_reg;
    assign res.clock_value   = out_value_reg;
    assign res.last          = out_last_reg;
    assign res.error         = out_error_reg;

endmodule

// ===== rtl/vct_ram.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker RAM
// Simple dual-port synchronous RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module vct_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/vct_join.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker join unit
// Per-component update: own increment with saturation, then acquire or
// release merge by maximum.
// ----------------------------------------------------------------------------
module vct_join import vct_pkg::*; (
    input  logic [CMD_W-1:0] cmd,
    input  logic             own,
    input  logic             tval,
    input  logic             lval,
    input  clock_t           thr_rdata,
    input  clock_t           lock_rdata,
    output clock_t           thr_new,
    output clock_t           lock_new
);

    clock_t thr_cur;
    clock_t lock_cur;
    clock_t thr_inc;

    always_comb
    begin
        // Rows never written take their reset values here in place of the RAM data.
        thr_cur  = tval ? thr_rdata : CLOCK_ONE;
        lock_cur = lval ? lock_rdata : '0;

        if (own && (thr_cur != CLOCK_MAX))
        begin
            thr_inc = thr_cur + CLOCK_ONE;
        end
        else
        begin
            thr_inc = thr_cur;
        end

        case (cmd)
            CMD_ACCESS:  thr_new = thr_inc;
            CMD_ACQUIRE: thr_new = clock_max(thr_inc, lock_cur);
            default:     thr_new = thr_inc;
        endcase

        lock_new = clock_max(thr_inc, lock_cur);
    end

endmodule

// ===== rtl/vct_ctrl.sv =====
// ----------------------------------------------------------------------------
// Vector clock tracker sequencer
// Takes event items, walks the snapshot elements through the memory read
// stage and keeps the per-row written flags.
// ----------------------------------------------------------------------------
`include "vector_clock_tracker_defines.svh"

module vct_ctrl import vct_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    vct_evt_if.sink  evt,
    input  logic     out_free,
    output vct_ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [ELEM_W-1:0]    rd_elem_reg, rd_elem_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ELEM_W-1:0]    tid_reg, tid_next;
    logic [LROW_W-1:0]    lid_reg, lid_next;
    logic                 tval_reg, tval_next;
    logic                 lval_reg, lval_next;
    logic [NUM_THREADS-1:0] thr_valid_reg, thr_valid_next;
    logic [NUM_LOCKS-1:0]   lock_valid_reg, lock_valid_next;

    logic accept;
    logic evt_err;
    logic adv;
    logic issue;
    logic is_last;

    assign evt.ready = (state_reg == S_IDLE);
    assign accept    = evt.valid && evt.ready;

    always_comb
    begin
        evt_err = (32'(evt.thread_id) >= 32'(NUM_THREADS)) ||
                  (((evt.cmd == CMD_ACQUIRE) || (evt.cmd == CMD_RELEASE)) &&
                   (32'(evt.lock_id) >= 32'(NUM_LOCKS)));

        adv     = (state_reg == S_RUN) && rd_valid_reg && out_free;
        issue   = (state_reg == S_RUN) && (iss_cnt_reg < CNT_W'(NUM_THREADS)) &&
                  (!rd_valid_reg || adv);
        is_last = (rd_elem_reg == ELEM_W'(NUM_THREADS - 1));

        state_next      = state_reg;
        iss_cnt_next    = iss_cnt_reg;
        rd_valid_next   = rd_valid_reg;
        rd_elem_next    = rd_elem_reg;
        cmd_next        = cmd_reg;
        tid_next        = tid_reg;
        lid_next        = lid_reg;
        tval_next       = tval_reg;
        lval_next       = lval_reg;
        thr_valid_next  = thr_valid_reg;
        lock_valid_next = lock_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = evt.cmd;
                    tid_next     = ELEM_W'(evt.thread_id);
                    lid_next     = LROW_W'(evt.lock_id);
                    tval_next    = thr_valid_reg[ELEM_W'(evt.thread_id)];
                    lval_next    = lock_valid_reg[LROW_W'(evt.lock_id)];
                    iss_cnt_next = '0;
                    state_next   = evt_err ? S_ERR : S_RUN;
                end
            end
            S_RUN:
            begin
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    rd_elem_next  = iss_cnt_reg[ELEM_W-1:0];
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                end
                else if (adv)
                begin
                    rd_valid_next = 1'b0;
                end

                // Whole rows are written by then, so the flags can be raised.
                if (adv && is_last)
                begin
                    thr_valid_next[tid_reg] = 1'b1;
                    if (cmd_reg == CMD_RELEASE)
                    begin
                        lock_valid_next[lid_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_cnt_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            thr_valid_reg  <= '0;
            lock_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_cnt_reg    <= iss_cnt_next;
            rd_valid_reg   <= rd_valid_next;
            thr_valid_reg  <= thr_valid_next;
            lock_valid_reg <= lock_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_elem_reg <= rd_elem_next;
        cmd_reg     <= cmd_next;
        tid_reg     <= tid_next;
        lid_reg     <= lid_next;
        tval_reg    <= tval_next;
        lval_reg    <= lval_next;
    end

    always_comb
    begin
        ctl.issue      = issue;
        ctl.issue_elem = iss_cnt_reg[ELEM_W-1:0];
        ctl.adv        = adv;
        ctl.rd_elem    = rd_elem_reg;
        ctl.is_last    = is_last;
        ctl.err_load   = (state_reg == S_ERR) && out_free;
        ctl.cmd        = cmd_reg;
        ctl.tid_row    = tid_reg;
        ctl.lid_row    = lid_reg;
        ctl.tval       = tval_reg;
        ctl.lval       = lval_reg;
    end

    `VCT_ASSERT_IMP(a_ready_empty, clk, rst_n, evt.ready, !rd_valid_reg && !ctl.issue)
    `VCT_ASSERT_NXT(a_last_idle, clk, rst_n, ctl.adv && ctl.is_last, state_reg == S_IDLE)
    `VCT_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, iss_cnt_reg <= CNT_W'(NUM_THREADS))
    `VCT_ASSERT_IMP(a_elem_order, clk, rst_n, ctl.issue && rd_valid_reg,
                    ctl.issue_elem == ELEM_W'(rd_elem_reg + 1'b1))

endmodule
